@@ rtl/core/ppf_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the pure pursuit path follower
package ppf_pkg;

  localparam int unsigned PPF_PATH_DEPTH = 1024;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_CANCEL = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_FOLLOW  = 3'd0,
    ST_REACHED = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_CANCEL  = 3'd3,
    ST_IDLE    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_LOOKAHEAD = 2'd0,
    REG_MAX_LIN   = 2'd1,
    REG_MAX_ANG   = 2'd2,
    REG_GOAL_TOL  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    DS_DIV  = 1'b0,
    DS_SQRT = 1'b1
  } ds_op_e;

  localparam logic [30:0] RST_LOOKAHEAD = 31'd52429;
  localparam logic [30:0] RST_MAX_LIN   = 31'd32768;
  localparam logic [30:0] RST_MAX_ANG   = 31'd65536;
  localparam logic [30:0] RST_GOAL_TOL  = 31'd19661;

  localparam logic [31:0] MIN_LD     = 32'd655;
  localparam logic [30:0] MIN_SPEED  = 31'd6554;
  localparam logic [16:0] TURN_FLOOR = 17'd19661;
  localparam logic [25:0] TURN_KNEE  = 26'd32768;
  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam logic [13:0] OCTANT     = 14'd8192;

  // floor(x/d) = (x*m) >> s for x below 2^30
  localparam logic [63:0] RECIP_6     = ((64'd1 << 33) + 64'd5) / 64'd6;
  localparam logic [63:0] RECIP_24    = ((64'd1 << 35) + 64'd23) / 64'd24;
  localparam logic [63:0] RECIP_120   = ((64'd1 << 37) + 64'd119) / 64'd120;
  localparam logic [63:0] RECIP_720   = ((64'd1 << 40) + 64'd719) / 64'd720;
  localparam logic [63:0] RECIP_5040  = ((64'd1 << 43) + 64'd5039) / 64'd5040;
  localparam logic [63:0] RECIP_40320 = ((64'd1 << 46) + 64'd40319) / 64'd40320;

endpackage

@@ rtl/core/ppf_cmd_if.sv @@
`timescale 1ns / 1ps
// command channel: path edits and pose ticks
interface ppf_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;

  modport source (output valid, action, pos_x, pos_y, heading, input ready);
  modport sink (input valid, action, pos_x, pos_y, heading, output ready);
endinterface

@@ rtl/core/ppf_res_if.sv @@
`timescale 1ns / 1ps
// result channel: velocity command and status
interface ppf_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] linear_speed;
  logic signed [31:0] angular_speed;
  logic [31:0]        goal_distance;
  logic [2:0]         status;

  modport source (output valid, linear_speed, angular_speed, goal_distance, status,
                  input ready);
  modport sink (input valid, linear_speed, angular_speed, goal_distance, status,
                output ready);
endinterface

@@ rtl/core/ppf_cfg_if.sv @@
`timescale 1ns / 1ps
// configuration write channel
interface ppf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/ppf_divsqrt.sv @@
`timescale 1ns / 1ps
// iterative unsigned divider and integer square root, one bit per cycle
module ppf_divsqrt
  import ppf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  ds_op_e      op_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  ds_op_e      op_q, op_d;
  logic [63:0] n_q, n_d;
  logic [34:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [34:0] trial;
  logic [34:0] sub;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    n_d    = n_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    trial  = '0;
    sub    = '0;
    if (start_i) begin
      busy_d = 1'b1;
      op_d   = op_i;
      n_d    = num_i;
      rem_d  = '0;
      quo_d  = '0;
      den_d  = den_i;
      cnt_d  = (op_i == DS_SQRT) ? 6'd31 : 6'd63;
    end else if (busy_q) begin
      if (op_q == DS_SQRT) begin
        trial = {rem_q[32:0], n_q[63:62]};
        sub   = {1'b0, quo_q[31:0], 2'b01};
        n_d   = {n_q[61:0], 2'b00};
      end else begin
        trial = {rem_q[33:0], n_q[63]};
        sub   = {3'b000, den_q};
        n_d   = {n_q[62:0], 1'b0};
      end
      if (trial >= sub) begin
        rem_d = trial - sub;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= DS_DIV;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign res_o  = quo_q;

endmodule

@@ rtl/core/pure_pursuit_path_follower_top.sv @@
`timescale 1ns / 1ps
// pure pursuit path follower: path memory, search walker and command sequencer
//
// cmd_i carries one item per action: clear path, append point, pose tick or
// cancel. clear and append give no result. cancel and every pose tick give
// exactly one item on res_o. cfg_i writes the lookahead, speed limits and
// goal tolerance; it is always ready. the user must write it only while
// idle; the block itself does not enforce this. a tick walks the stored
// points one per cycle through the point memory read port: once from the
// remembered nearest point to the end, then from the closest point until
// the lookahead radius is crossed or the path ends. the rest runs on one
// shared multiplier and a divide and square root unit that resolves one bit
// per cycle.
// cmd_i is ready only when no item is in work. a finished result sits in the
// output register; while res_o is stalled the next item is still taken, and
// its result waits until the register is free.
// reset empties the path, stops following and loads the register defaults;
// point memory contents are not cleared.
module pure_pursuit_path_follower_top
  import ppf_pkg::*;
#(
  parameter int unsigned PATH_DEPTH = PPF_PATH_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppf_cmd_if.sink   cmd_i,
  ppf_cfg_if.sink   cfg_i,
  ppf_res_if.source res_o
);

  localparam int unsigned AW = $clog2(PATH_DEPTH);
  localparam int unsigned CW = $clog2(PATH_DEPTH + 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_GOAL  = 13'b0000000000010,
    S_GSQRT = 13'b0000000000100,
    S_NEAR  = 13'b0000000001000,
    S_LOOK  = 13'b0000000010000,
    S_LSQRT = 13'b0000000100000,
    S_TRIG  = 13'b0000001000000,
    S_ROT   = 13'b0000010000000,
    S_RDIV  = 13'b0000100000000,
    S_KDIV  = 13'b0001000000000,
    S_SPEED = 13'b0010000000000,
    S_TURN  = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_e;

  // point memory
  logic signed [31:0] x_mem [PATH_DEPTH];
  logic signed [31:0] y_mem [PATH_DEPTH];

  state_e             state_q, state_d;
  logic [3:0]         step_q, step_d;
  logic signed [31:0] px_q, px_d, py_q, py_d;
  logic [15:0]        hd_q, hd_d;
  logic [30:0]        la_q, la_d, maxl_q, maxl_d, maxa_q, maxa_d, tol_q, tol_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      near_q, near_d, closest_q, closest_d;
  logic               follow_q, follow_d, first_q, first_d;
  logic [63:0]        gd2_q, gd2_d, best_q, best_d, l2_q, l2_d, lad2_q, lad2_d;
  logic [31:0]        gd_q, gd_d, ld_q, ld_d;
  logic signed [32:0] ldx_q, ldx_d, ldy_q, ldy_d;
  logic [29:0]        x_q, x_d, x2_q, x2_d, x3_q, x3_d, x4_q, x4_d;
  logic [29:0]        x5_q, x5_d, x6_q, x6_d, x7_q, x7_d, x8_q, x8_d;
  logic signed [33:0] sacc_q, sacc_d, cacc_q, cacc_d;
  logic signed [65:0] p1_q, p1_d;
  logic signed [35:0] ly_q, ly_d;
  logic [17:0]        ratio_q, ratio_d;
  logic [25:0]        ak_q, ak_d;
  logic [30:0]        lin_q, lin_d;
  logic signed [31:0] rlin_q, rlin_d, rang_q, rang_d;
  logic [31:0]        rgd_q, rgd_d;
  status_e            rst_q, rst_d;
  logic               ovalid_q, ovalid_d;
  logic signed [31:0] olin_q, olin_d, oang_q, oang_d;
  logic [31:0]        ogd_q, ogd_d;
  status_e            ost_q, ost_d;

  // walker
  logic               walk_go, walk_stop;
  logic [AW-1:0]      walk_addr;
  logic [AW-1:0]      iss_q;
  logic               run_q, v1_q, v2_q, v3_q;
  logic [AW-1:0]      idx1_q, idx2_q, idx3_q;
  logic signed [31:0] rdx_q, rdy_q;
  logic signed [32:0] dx2_q, dy2_q, dx3_q, dy3_q;
  logic [31:0]        ax2_q, ay2_q;
  logic [63:0]        sqx_q, sqy_q;
  logic signed [32:0] dx_c, dy_c;
  logic [64:0]        sum_c;
  logic [63:0]        d_c;
  logic [AW-1:0]      last_c;

  // shared multiplier and divide/root unit
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_q;
  logic               ds_start, ds_done;
  ds_op_e             ds_op;
  logic [63:0]        ds_num, ds_res;
  logic [31:0]        ds_den;

  logic               cmd_acc;
  action_e            act;
  logic               upd_c;
  logic [AW-1:0]      cl_c;
  logic [13:0]        r_c;
  logic               swap_c;
  logic [14:0]        ro_c;
  logic [29:0]        xs_c, pw_c;
  logic signed [33:0] s0_c, c0_c, sin_c, cos_c;
  logic signed [65:0] diff_c;
  logic [35:0]        lymag_c;
  logic signed [26:0] k_c;
  logic [24:0]        half_c;
  logic [16:0]        fac_c;
  logic [30:0]        linn_c, linf_c;
  logic signed [51:0] ang_c, maxa_c, angf_c;

  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign act         = action_e'(cmd_i.action);
  assign cmd_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign last_c = AW'(cnt_q - CW'(1));
  assign sum_c  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign d_c    = sum_c[64] ? '1 : sum_c[63:0];
  assign upd_c  = first_q || (d_c < best_q);
  assign cl_c   = upd_c ? idx3_q : closest_q;

  assign r_c    = hd_q[13:0];
  assign swap_c = (r_c > OCTANT);
  assign ro_c   = swap_c ? (15'd16384 - {1'b0, r_c}) : {1'b0, r_c};
  assign xs_c   = mul_q[44:15];
  assign pw_c   = mul_q[59:30];
  assign s0_c   = swap_c ? cacc_q : sacc_q;
  assign c0_c   = swap_c ? sacc_q : cacc_q;

  always_comb begin
    case (hd_q[15:14])
      2'd0: begin
        sin_c = s0_c;
        cos_c = c0_c;
      end
      2'd1: begin
        sin_c = c0_c;
        cos_c = -s0_c;
      end
      2'd2: begin
        sin_c = -s0_c;
        cos_c = -c0_c;
      end
      default: begin
        sin_c = -c0_c;
        cos_c = s0_c;
      end
    endcase
  end

  assign diff_c  = p1_q - mul_q[65:0];
  assign lymag_c = ly_q[35] ? 36'(-ly_q) : 36'(ly_q);
  assign k_c     = ly_q[35] ? -$signed({1'b0, ak_q}) : $signed({1'b0, ak_q});
  assign half_c  = ak_q[25:1];
  assign fac_c   = (half_c >= 25'd65536) ? 17'd0 : 17'(25'd65536 - half_c);
  assign linn_c  = mul_q[46:16];
  assign linf_c  = (lin_q > maxl_q) ? maxl_q : lin_q;
  assign ang_c   = mul_q[67:16];
  assign maxa_c  = $signed({21'b0, maxa_q});
  assign angf_c  = (ang_c > maxa_c) ? maxa_c : ((ang_c < -maxa_c) ? -maxa_c : ang_c);

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    px_d      = px_q;
    py_d      = py_q;
    hd_d      = hd_q;
    la_d      = la_q;
    maxl_d    = maxl_q;
    maxa_d    = maxa_q;
    tol_d     = tol_q;
    cnt_d     = cnt_q;
    near_d    = near_q;
    closest_d = closest_q;
    follow_d  = follow_q;
    first_d   = first_q;
    gd2_d     = gd2_q;
    best_d    = best_q;
    l2_d      = l2_q;
    lad2_d    = lad2_q;
    gd_d      = gd_q;
    ld_d      = ld_q;
    ldx_d     = ldx_q;
    ldy_d     = ldy_q;
    x_d       = x_q;
    x2_d      = x2_q;
    x3_d      = x3_q;
    x4_d      = x4_q;
    x5_d      = x5_q;
    x6_d      = x6_q;
    x7_d      = x7_q;
    x8_d      = x8_q;
    sacc_d    = sacc_q;
    cacc_d    = cacc_q;
    p1_d      = p1_q;
    ly_d      = ly_q;
    ratio_d   = ratio_q;
    ak_d      = ak_q;
    lin_d     = lin_q;
    rlin_d    = rlin_q;
    rang_d    = rang_q;
    rgd_d     = rgd_q;
    rst_d     = rst_q;
    ovalid_d  = ovalid_q && !res_o.ready;
    olin_d    = olin_q;
    oang_d    = oang_q;
    ogd_d     = ogd_q;
    ost_d     = ost_q;
    walk_go   = 1'b0;
    walk_stop = 1'b0;
    walk_addr = '0;
    mul_a     = '0;
    mul_b     = '0;
    ds_start  = 1'b0;
    ds_op     = DS_DIV;
    ds_num    = '0;
    ds_den    = '0;

    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        REG_LOOKAHEAD: la_d   = cfg_i.data[30:0];
        REG_MAX_LIN:   maxl_d = cfg_i.data[30:0];
        REG_MAX_ANG:   maxa_d = cfg_i.data[30:0];
        REG_GOAL_TOL:  tol_d  = cfg_i.data[30:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_acc) begin
          rlin_d = '0;
          rang_d = '0;
          rgd_d  = '0;
          case (act)
            ACT_CLEAR: begin
              cnt_d    = '0;
              near_d   = '0;
              follow_d = 1'b1;
            end
            ACT_APPEND: begin
              if (cnt_q < CW'(PATH_DEPTH)) begin
                cnt_d = cnt_q + CW'(1);
              end
            end
            ACT_CANCEL: begin
              follow_d = 1'b0;
              rst_d    = ST_CANCEL;
              state_d  = S_EMIT;
            end
            ACT_TICK: begin
              px_d = cmd_i.pos_x;
              py_d = cmd_i.pos_y;
              hd_d = cmd_i.heading;
              if (!follow_q) begin
                rst_d   = ST_IDLE;
                state_d = S_EMIT;
              end else if (cnt_q == '0) begin
                follow_d = 1'b0;
                rst_d    = ST_EMPTY;
                state_d  = S_EMIT;
              end else begin
                walk_go   = 1'b1;
                walk_addr = last_c;
                state_d   = S_GOAL;
              end
            end
            default: ;
          endcase
        end
      end

      S_GOAL: begin
        if (v3_q) begin
          gd2_d     = d_c;
          walk_stop = 1'b1;
          step_d    = '0;
          state_d   = S_GSQRT;
        end
      end

      S_GSQRT: begin
        mul_a = 34'(tol_q);
        mul_b = 34'(tol_q);
        if (step_q == '0) begin
          ds_start = 1'b1;
          ds_op    = DS_SQRT;
          ds_num   = gd2_q;
          step_d   = 4'd1;
        end else if (ds_done) begin
          gd_d = ds_res[31:0];
          if (gd2_q < mul_q[63:0]) begin
            follow_d = 1'b0;
            rgd_d    = ds_res[31:0];
            rst_d    = ST_REACHED;
            state_d  = S_EMIT;
          end else begin
            walk_go   = 1'b1;
            walk_addr = (CW'(near_q) >= cnt_q) ? '0 : near_q;
            first_d   = 1'b1;
            state_d   = S_NEAR;
          end
        end
      end

      S_NEAR: begin
        mul_a = 34'(la_q);
        mul_b = 34'(la_q);
        if (v3_q) begin
          if (upd_c) begin
            best_d    = d_c;
            closest_d = idx3_q;
            first_d   = 1'b0;
          end
          if (idx3_q == last_c) begin
            near_d    = cl_c;
            l2_d      = mul_q[63:0];
            walk_go   = 1'b1;
            walk_addr = cl_c;
            state_d   = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        if (v3_q) begin
          ldx_d  = dx3_q;
          ldy_d  = dy3_q;
          lad2_d = d_c;
          if ((d_c >= l2_q) || (idx3_q == last_c)) begin
            walk_stop = 1'b1;
            step_d    = '0;
            state_d   = S_LSQRT;
          end
        end
      end

      S_LSQRT: begin
        if (step_q == '0) begin
          ds_start = 1'b1;
          ds_op    = DS_SQRT;
          ds_num   = lad2_q;
          step_d   = 4'd1;
        end else if (ds_done) begin
          ld_d    = (ds_res[31:0] < MIN_LD) ? MIN_LD : ds_res[31:0];
          step_d  = '0;
          state_d = S_TRIG;
        end
      end

      S_TRIG: begin
        step_d = step_q + 4'd1;
        case (step_q)
          4'd0: begin
            mul_a = 34'(ro_c);
            mul_b = 34'(PI_Q30);
          end
          4'd1: begin
            x_d    = xs_c;
            sacc_d = 34'(xs_c);
            mul_a  = 34'(xs_c);
            mul_b  = 34'(xs_c);
          end
          4'd2: begin
            x2_d   = pw_c;
            cacc_d = 34'(31'd1073741824 - 31'(pw_c[29:1]));
            mul_a  = 34'(pw_c);
            mul_b  = 34'(x_q);
          end
          4'd3: begin
            x3_d  = pw_c;
            mul_a = 34'(x2_q);
            mul_b = 34'(x2_q);
          end
          4'd4: begin
            x4_d  = pw_c;
            mul_a = 34'(pw_c);
            mul_b = 34'(x_q);
          end
          4'd5: begin
            x5_d  = pw_c;
            mul_a = 34'(x4_q);
            mul_b = 34'(x2_q);
          end
          4'd6: begin
            x6_d  = pw_c;
            mul_a = 34'(pw_c);
            mul_b = 34'(x_q);
          end
          4'd7: begin
            x7_d  = pw_c;
            mul_a = 34'(x4_q);
            mul_b = 34'(x4_q);
          end
          4'd8: begin
            x8_d  = pw_c;
            mul_a = 34'(x3_q);
            mul_b = 34'(RECIP_6);
          end
          4'd9: begin
            sacc_d = sacc_q - 34'(mul_q[62:33]);
            mul_a  = 34'(x5_q);
            mul_b  = 34'(RECIP_120);
          end
          4'd10: begin
            sacc_d = sacc_q + 34'(mul_q[66:37]);
            mul_a  = 34'(x7_q);
            mul_b  = 34'(RECIP_5040);
          end
          4'd11: begin
            sacc_d = sacc_q - 34'(mul_q[66:43]);
            mul_a  = 34'(x4_q);
            mul_b  = 34'(RECIP_24);
          end
          4'd12: begin
            cacc_d = cacc_q + 34'(mul_q[64:35]);
            mul_a  = 34'(x6_q);
            mul_b  = 34'(RECIP_720);
          end
          4'd13: begin
            cacc_d = cacc_q - 34'(mul_q[66:40]);
            mul_a  = 34'(x8_q);
            mul_b  = 34'(RECIP_40320);
          end
          default: begin
            cacc_d  = cacc_q + 34'(mul_q[66:46]);
            step_d  = '0;
            state_d = S_ROT;
          end
        endcase
      end

      S_ROT: begin
        step_d = step_q + 4'd1;
        case (step_q)
          4'd0: begin
            mul_a = 34'(ldy_q);
            mul_b = cos_c;
          end
          4'd1: begin
            p1_d  = mul_q[65:0];
            mul_a = 34'(ldx_q);
            mul_b = sin_c;
          end
          default: begin
            ly_d    = diff_c[65:30];
            step_d  = '0;
            state_d = S_RDIV;
          end
        endcase
      end

      S_RDIV: begin
        if (step_q == '0) begin
          ds_start = 1'b1;
          ds_num   = 64'({lymag_c[34:0], 16'b0});
          ds_den   = ld_q;
          step_d   = 4'd1;
        end else if (ds_done) begin
          ratio_d = (ds_res > 64'd131072) ? 18'd131072 : ds_res[17:0];
          step_d  = '0;
          state_d = S_KDIV;
        end
      end

      S_KDIV: begin
        if (step_q == '0) begin
          ds_start = 1'b1;
          ds_num   = 64'({ratio_q, 17'b0});
          ds_den   = ld_q;
          step_d   = 4'd1;
        end else if (ds_done) begin
          ak_d    = ds_res[25:0];
          step_d  = '0;
          state_d = S_SPEED;
        end
      end

      S_SPEED: begin
        case (step_q)
          4'd0: begin
            mul_a = 34'(maxl_q);
            mul_b = 34'(gd_q);
            if ({2'b00, gd2_q} < {l2_q, 2'b00}) begin
              step_d = 4'd1;
            end else begin
              lin_d   = maxl_q;
              step_d  = '0;
              state_d = S_TURN;
            end
          end
          4'd1: begin
            ds_start = 1'b1;
            ds_num   = mul_q[63:0];
            ds_den   = {la_q, 1'b0};
            step_d   = 4'd2;
          end
          default: begin
            if (ds_done) begin
              lin_d   = (ds_res < 64'(MIN_SPEED)) ? MIN_SPEED : ds_res[30:0];
              step_d  = '0;
              state_d = S_TURN;
            end
          end
        endcase
      end

      S_TURN: begin
        case (step_q)
          4'd0: begin
            if (ak_q > TURN_KNEE) begin
              mul_a  = 34'(lin_q);
              mul_b  = 34'((fac_c < TURN_FLOOR) ? TURN_FLOOR : fac_c);
              step_d = 4'd1;
            end else begin
              mul_a  = 34'(lin_q);
              mul_b  = 34'(k_c);
              step_d = 4'd2;
            end
          end
          4'd1: begin
            lin_d  = linn_c;
            mul_a  = 34'(linn_c);
            mul_b  = 34'(k_c);
            step_d = 4'd2;
          end
          default: begin
            rlin_d  = $signed({1'b0, linf_c});
            rang_d  = angf_c[31:0];
            rgd_d   = gd_q;
            rst_d   = ST_FOLLOW;
            step_d  = '0;
            state_d = S_EMIT;
          end
        endcase
      end

      S_EMIT: begin
        if (!ovalid_q || res_o.ready) begin
          ovalid_d = 1'b1;
          olin_d   = rlin_q;
          oang_d   = rang_q;
          ogd_d    = rgd_q;
          ost_d    = rst_q;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      la_q     <= RST_LOOKAHEAD;
      maxl_q   <= RST_MAX_LIN;
      maxa_q   <= RST_MAX_ANG;
      tol_q    <= RST_GOAL_TOL;
      cnt_q    <= '0;
      near_q   <= '0;
      follow_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      la_q     <= la_d;
      maxl_q   <= maxl_d;
      maxa_q   <= maxa_d;
      tol_q    <= tol_d;
      cnt_q    <= cnt_d;
      near_q   <= near_d;
      follow_q <= follow_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q      <= px_d;
    py_q      <= py_d;
    hd_q      <= hd_d;
    closest_q <= closest_d;
    first_q   <= first_d;
    gd2_q     <= gd2_d;
    best_q    <= best_d;
    l2_q      <= l2_d;
    lad2_q    <= lad2_d;
    gd_q      <= gd_d;
    ld_q      <= ld_d;
    ldx_q     <= ldx_d;
    ldy_q     <= ldy_d;
    x_q       <= x_d;
    x2_q      <= x2_d;
    x3_q      <= x3_d;
    x4_q      <= x4_d;
    x5_q      <= x5_d;
    x6_q      <= x6_d;
    x7_q      <= x7_d;
    x8_q      <= x8_d;
    sacc_q    <= sacc_d;
    cacc_q    <= cacc_d;
    p1_q      <= p1_d;
    ly_q      <= ly_d;
    ratio_q   <= ratio_d;
    ak_q      <= ak_d;
    lin_q     <= lin_d;
    rlin_q    <= rlin_d;
    rang_q    <= rang_d;
    rgd_q     <= rgd_d;
    rst_q     <= rst_d;
    olin_q    <= olin_d;
    oang_q    <= oang_d;
    ogd_q     <= ogd_d;
    ost_q     <= ost_d;
    mul_q     <= mul_a * mul_b;
  end

  // point memory write and read
  always_ff @(posedge clk_i) begin
    if (cmd_acc && (act == ACT_APPEND) && (cnt_q < CW'(PATH_DEPTH))) begin
      x_mem[cnt_q[AW-1:0]] <= cmd_i.pos_x;
      y_mem[cnt_q[AW-1:0]] <= cmd_i.pos_y;
    end
    if (run_q) begin
      rdx_q <= x_mem[iss_q];
      rdy_q <= y_mem[iss_q];
    end
  end

  // walker control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= '0;
      run_q <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else if (walk_go) begin
      iss_q <= walk_addr;
      run_q <= 1'b1;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else if (walk_stop) begin
      run_q <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (run_q) begin
        iss_q <= iss_q + AW'(1);
        run_q <= (iss_q != last_c);
      end
      v1_q <= run_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign dx_c = 33'(rdx_q) - 33'(px_q);
  assign dy_c = 33'(rdy_q) - 33'(py_q);

  // squared distance stages
  always_ff @(posedge clk_i) begin
    idx1_q <= iss_q;
    idx2_q <= idx1_q;
    dx2_q  <= dx_c;
    dy2_q  <= dy_c;
    ax2_q  <= dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
    ay2_q  <= dy_c[32] ? 32'(-dy_c) : dy_c[31:0];
    idx3_q <= idx2_q;
    dx3_q  <= dx2_q;
    dy3_q  <= dy2_q;
    sqx_q  <= ax2_q * ax2_q;
    sqy_q  <= ay2_q * ay2_q;
  end

  ppf_divsqrt u_divsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ds_start),
    .op_i    (ds_op),
    .num_i   (ds_num),
    .den_i   (ds_den),
    .done_o  (ds_done),
    .res_o   (ds_res)
  );

  assign res_o.valid         = ovalid_q;
  assign res_o.linear_speed  = olin_q;
  assign res_o.angular_speed = oang_q;
  assign res_o.goal_distance = ogd_q;
  assign res_o.status        = ost_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ready |-> (state_q == S_IDLE))
    else $error("command taken while busy");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status != ST_FOLLOW)) |->
      ((res_o.linear_speed == '0) && (res_o.angular_speed == '0)))
    else $error("nonzero speed on stopped result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(PATH_DEPTH))
    else $error("path count above depth");

  a_walk_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !run_q)
    else $error("walker running while idle");
`endif

endmodule

@@ test/pure_pursuit_path_follower_top_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the pure pursuit path follower with its own command predictor
module pure_pursuit_path_follower_top_test;
  import ppf_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] lin;
    logic signed [31:0] ang;
    logic [31:0]        gd;
    status_e            st;
  } cmd_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ppf_cmd_if cmd ();
  ppf_res_if res ();
  ppf_cfg_if cfg ();

  pure_pursuit_path_follower_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [30:0]        lookahead_q = RST_LOOKAHEAD;
  logic [30:0]        max_lin_q   = RST_MAX_LIN;
  logic [30:0]        max_ang_q   = RST_MAX_ANG;
  logic [30:0]        goal_tol_q  = RST_GOAL_TOL;
  logic signed [31:0] pt_x [PPF_PATH_DEPTH];
  logic signed [31:0] pt_y [PPF_PATH_DEPTH];
  int unsigned        pt_count = 0;
  int unsigned        nearest_q = 0;
  bit                 following = 1'b0;

  cmd_result_t  expected_cmds [$];
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  hold_left = 0;
  bit           no_gap = 1'b0;
  bit           no_stall = 1'b0;

  function automatic longint unsigned sq_dist(int unsigned idx, longint rx, longint ry);
    longint            dx, dy;
    longint unsigned   ax, ay, a, b;
    logic [64:0]       s;
    dx = longint'(pt_x[idx]) - rx;
    dy = longint'(pt_y[idx]) - ry;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    a = ax * ax;
    b = ay * ay;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic logic [31:0] int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic void octant_trig(input int unsigned r, output longint sn, output longint cs);
    longint unsigned x, x2, x3, x4, x5, x6, x7, x8;
    x  = (longint'(r) * longint'(PI_Q30)) >> 15;
    x2 = (x * x) >> 30;
    x3 = (x2 * x) >> 30;
    x4 = (x2 * x2) >> 30;
    x5 = (x4 * x) >> 30;
    x6 = (x4 * x2) >> 30;
    x7 = (x6 * x) >> 30;
    x8 = (x4 * x4) >> 30;
    sn = longint'(x) - longint'(x3 / 6) + longint'(x5 / 120) - longint'(x7 / 5040);
    cs = (longint'(1) << 30) - longint'(x2 / 2) + longint'(x4 / 24)
         - longint'(x6 / 720) + longint'(x8 / 40320);
  endfunction

  function automatic void heading_trig(input logic [15:0] h, output longint sn,
                                       output longint cs);
    longint s0, c0;
    if (h[13:0] <= OCTANT) begin
      octant_trig(h[13:0], s0, c0);
    end else begin
      octant_trig(16384 - h[13:0], c0, s0);
    end
    case (h[15:14])
      2'd0: begin sn = s0;  cs = c0;  end
      2'd1: begin sn = c0;  cs = -s0; end
      2'd2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
  endfunction

  function automatic cmd_result_t stop_cmd(logic [31:0] gd, status_e st);
    cmd_result_t r;
    r.lin = '0;
    r.ang = '0;
    r.gd  = gd;
    r.st  = st;
    return r;
  endfunction

  function automatic cmd_result_t pursue(longint px, longint py, logic [15:0] h);
    cmd_result_t      r;
    longint unsigned  gd2, best, d, l2, lad2, rq, ratio, ak, v, half, fac, four_l2;
    logic [31:0]      gd, ld;
    int unsigned      closest, look;
    longint           sn, cs, dx, dy, ly, k, lin, ang, maxang;
    gd2 = sq_dist(pt_count - 1, px, py);
    gd = int_sqrt(gd2);
    if (gd2 < longint'(goal_tol_q) * longint'(goal_tol_q)) begin
      following = 1'b0;
      return stop_cmd(gd, ST_REACHED);
    end
    if (nearest_q >= pt_count) nearest_q = 0;
    closest = nearest_q;
    best = 0;
    for (int unsigned i = nearest_q; i < pt_count; i++) begin
      d = sq_dist(i, px, py);
      if (i == nearest_q || d < best) begin
        best = d;
        closest = i;
      end
    end
    nearest_q = closest;
    l2 = longint'(lookahead_q) * longint'(lookahead_q);
    look = closest;
    lad2 = 0;
    for (int unsigned i = closest; i < pt_count; i++) begin
      look = i;
      lad2 = sq_dist(i, px, py);
      if (lad2 >= l2) break;
    end
    heading_trig(h, sn, cs);
    dx = longint'(pt_x[look]) - px;
    dy = longint'(pt_y[look]) - py;
    ly = (dy * cs - dx * sn) >>> 30;
    ld = int_sqrt(lad2);
    if (ld < MIN_LD) ld = MIN_LD;
    rq = ((ly < 0) ? longint'(-ly) : longint'(ly)) << 16;
    rq = rq / ld;
    ratio = (rq > (64'd1 << 17)) ? (64'd1 << 17) : rq;
    ak = (ratio << 17) / ld;
    k = (ly < 0) ? -longint'(ak) : longint'(ak);
    lin = longint'(max_lin_q);
    four_l2 = l2 << 2;
    if (gd2 < four_l2) begin
      v = (longint'(max_lin_q) * longint'(gd)) / (2 * longint'(lookahead_q));
      lin = (v < MIN_SPEED) ? longint'(MIN_SPEED) : longint'(v);
    end
    if (ak > TURN_KNEE) begin
      half = ak >> 1;
      fac = (half >= 65536) ? 0 : 65536 - half;
      if (fac < TURN_FLOOR) fac = TURN_FLOOR;
      lin = longint'((longint'(lin) * fac) >> 16);
    end
    ang = (lin * k) >>> 16;
    if (lin > longint'(max_lin_q)) lin = longint'(max_lin_q);
    maxang = longint'(max_ang_q);
    if (ang > maxang) ang = maxang;
    if (ang < -maxang) ang = -maxang;
    r.lin = lin[31:0];
    r.ang = ang[31:0];
    r.gd  = gd;
    r.st  = ST_FOLLOW;
    return r;
  endfunction

  function automatic void predict_cmd(action_e act, logic signed [31:0] x,
                                      logic signed [31:0] y, logic [15:0] h);
    case (act)
      ACT_CLEAR: begin
        pt_count = 0;
        nearest_q = 0;
        following = 1'b1;
      end
      ACT_APPEND: begin
        if (pt_count < PPF_PATH_DEPTH) begin
          pt_x[pt_count] = x;
          pt_y[pt_count] = y;
          pt_count++;
        end
      end
      ACT_CANCEL: begin
        following = 1'b0;
        expected_cmds.push_back(stop_cmd('0, ST_CANCEL));
      end
      default: begin
        if (!following) begin
          expected_cmds.push_back(stop_cmd('0, ST_IDLE));
        end else if (pt_count == 0) begin
          following = 1'b0;
          expected_cmds.push_back(stop_cmd('0, ST_EMPTY));
        end else begin
          expected_cmds.push_back(pursue(longint'(x), longint'(y), h));
        end
      end
    endcase
  endfunction

  task automatic send_cmd(action_e act, logic signed [31:0] x, logic signed [31:0] y,
                          logic [15:0] h);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd.valid   <= 1'b1;
    cmd.action  <= act;
    cmd.pos_x   <= x;
    cmd.pos_y   <= y;
    cmd.heading <= h;
    do @(posedge clk_i); while (!cmd.ready);
    predict_cmd(act, x, y, h);
  endtask

  task automatic drain_results();
    cmd.valid <= 1'b0;
    do @(posedge clk_i); while (expected_cmds.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      REG_LOOKAHEAD: lookahead_q = data[30:0];
      REG_MAX_LIN:   max_lin_q   = data[30:0];
      REG_MAX_ANG:   max_ang_q   = data[30:0];
      default:       goal_tol_q  = data[30:0];
    endcase
  endtask

  task automatic write_all(logic [31:0] la, logic [31:0] ml, logic [31:0] ma,
                           logic [31:0] gt);
    write_reg(REG_LOOKAHEAD, la);
    write_reg(REG_MAX_LIN, ml);
    write_reg(REG_MAX_ANG, ma);
    write_reg(REG_GOAL_TOL, gt);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(0, 9) < 8) return $signed($urandom_range(0, 1048576)) - 524288;
    return $urandom;
  endfunction

  // short path mostly starting near the origin, then ticks near its points mixed with random ticks, cancels and appends
  task automatic run_route(int unsigned n_pts, int unsigned n_ticks);
    logic signed [31:0] x, y;
    int unsigned p;
    send_cmd(ACT_CLEAR, $urandom, $urandom, $urandom);
    x = rand_coord();
    y = rand_coord();
    for (int i = 0; i < n_pts; i++) begin
      send_cmd(ACT_APPEND, x, y, $urandom);
      x = x + $signed($urandom_range(0, 131072)) - 32768;
      y = y + $signed($urandom_range(0, 131072)) - 65536;
    end
    for (int i = 0; i < n_ticks; i++) begin
      p = (pt_count == 0) ? 0 : $urandom_range(0, pt_count - 1);
      case ($urandom_range(0, 9))
        0: send_cmd(ACT_TICK, $urandom, $urandom, $urandom);
        1: send_cmd(ACT_CANCEL, $urandom, $urandom, $urandom);
        2: send_cmd(ACT_APPEND, x, y, $urandom);
        default: send_cmd(ACT_TICK, pt_x[p] + $signed($urandom_range(0, 65536)) - 32768,
                          pt_y[p] + $signed($urandom_range(0, 65536)) - 32768, $urandom);
      endcase
    end
  endtask

  task automatic test_directed();
    send_cmd(ACT_TICK, 0, 0, 0);
    send_cmd(ACT_CANCEL, 0, 0, 0);
    send_cmd(ACT_CLEAR, 0, 0, 0);
    send_cmd(ACT_TICK, 0, 0, 0);
    send_cmd(ACT_CLEAR, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_cmd(ACT_APPEND, i * 65536, i * 16384, 0);
    send_cmd(ACT_TICK, 0, 0, 16'd0);
    send_cmd(ACT_TICK, 0, -32768, 16'd16384);
    send_cmd(ACT_TICK, 10000, 0, 16'd32768);
    send_cmd(ACT_TICK, 20000, 9000, 16'd49152);
    send_cmd(ACT_TICK, 30000, 9000, 16'd8192);
    send_cmd(ACT_TICK, 40000, 0, 16'd8193);
    send_cmd(ACT_TICK, 50000, 20000, 16'hFFFF);
    send_cmd(ACT_TICK, 196608, 49152, 0);
    send_cmd(ACT_CLEAR, 0, 0, 0);
    send_cmd(ACT_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_cmd(ACT_APPEND, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF);
    send_cmd(ACT_TICK, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF);
    send_cmd(ACT_TICK, 32'sh8000_0000, 32'sh8000_0000, 16'h5555);
    send_cmd(ACT_CANCEL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hAAAA);
    drain_results();
  endtask

  task automatic test_config_extremes();
    write_all(0, 0, 0, 0);
    run_route(4, 5);
    drain_results();
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_route(4, 4);
    drain_results();
    write_all(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1000, 0);
    run_route(5, 5);
    drain_results();
    write_all(32'd655, 32'd200000, 32'd300000, 32'd1);
    run_route(6, 5);
    drain_results();
    write_all(RST_LOOKAHEAD, RST_MAX_LIN, RST_MAX_ANG, RST_GOAL_TOL);
  endtask

  task automatic test_full_path();
    no_gap = 1'b1;
    send_cmd(ACT_CLEAR, 0, 0, 0);
    for (int i = 0; i <= PPF_PATH_DEPTH; i++) begin
      send_cmd(ACT_APPEND, i * 8192, (i % 7) * 4096, 0);
    end
    no_gap = 1'b0;
    send_cmd(ACT_TICK, 0, 0, 0);
    send_cmd(ACT_TICK, 500 * 8192, 8192, 16'd1000);
    send_cmd(ACT_TICK, 1023 * 8192, 6 * 4096, 0);
    drain_results();
  endtask

  task automatic test_backpressure();
    send_cmd(ACT_CLEAR, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_cmd(ACT_APPEND, i * 40000, i * 20000, 0);
    hold_left = 400;
    for (int i = 0; i < 6; i++) begin
      send_cmd(ACT_TICK, i * 30000, 0, $urandom);
    end
    send_cmd(ACT_CANCEL, 0, 0, 0);
    drain_results();
  endtask

  task automatic test_sender_pause();
    run_route(5, 4);
    drain_results();
    for (int i = 0; i < 4; i++) send_cmd(ACT_TICK, rand_coord(), rand_coord(), $urandom);
    drain_results();
  endtask

  task automatic test_random();
    for (int i = 0; i < 16; i++) begin
      no_gap   = ($urandom_range(0, 3) == 0);
      no_stall = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        send_cmd(action_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
      end
      run_route($urandom_range(1, 10), $urandom_range(3, 10));
    end
    no_gap = 1'b0;
    no_stall = 1'b0;
    drain_results();
  endtask

  // result consumer
  initial begin
    int unsigned n;
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      n = no_stall ? 0 : $urandom_range(0, 11);
      if (n > 0 || hold_left != 0) begin
        res.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
        while (hold_left != 0) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    cmd_result_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected result item status %0d", res.status);
        errors++;
      end else begin
        e = expected_cmds.pop_front();
        if (res.linear_speed !== e.lin) begin
          $error("linear_speed expected %0d actual %0d", e.lin, res.linear_speed);
          errors++;
        end
        if (res.angular_speed !== e.ang) begin
          $error("angular_speed expected %0d actual %0d", e.ang, res.angular_speed);
          errors++;
        end
        if (res.goal_distance !== e.gd) begin
          $error("goal_distance expected %0d actual %0d", e.gd, res.goal_distance);
          errors++;
        end
        if (res.status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, res.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    cmd.valid   <= 1'b0;
    cmd.action  <= ACT_CLEAR;
    cmd.pos_x   <= '0;
    cmd.pos_y   <= '0;
    cmd.heading <= '0;
    cfg.valid   <= 1'b0;
    cfg.index   <= REG_LOOKAHEAD;
    cfg.data    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_full_path();
    test_backpressure();
    test_sender_pause();
    test_random();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ppf_pkg.sv
rtl/core/ppf_cmd_if.sv
rtl/core/ppf_res_if.sv
rtl/core/ppf_cfg_if.sv
rtl/core/ppf_divsqrt.sv
rtl/core/pure_pursuit_path_follower_top.sv
test/pure_pursuit_path_follower_top_test.sv
